// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and disabled while
// rst_ni is low. Both expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define HSJG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define HSJG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HSJG_ASSERT(lbl, prop, msg)
`define HSJG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/hsjg_pkg.sv =====
// ----------------------------------------------------------------------------
// hsjg_pkg
// Widths, register indexes, controller states and the command and status
// groups shared by the jitter generator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hsjg_pkg;

  localparam int CFG_W   = 15;  // configuration register width
  localparam int IDX_W   = 2;   // configuration index width
  localparam int FRAME_W = 32;  // frame index width
  localparam int PHASE_W = 17;  // phase output width
  localparam int JIT_W   = 32;  // jitter output width
  localparam int N_W     = 18;  // phase and phase+1 width
  localparam int DIV_W   = 20;  // divisor and remainder width of the divider
  localparam int BITS_W  = 32;  // dividend bits fed to the divider

  localparam logic [IDX_W-1:0] CFG_RENDER_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_RENDER_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] CFG_DISPLAY_WIDTH = 2'd2;

  localparam logic [CFG_W-1:0] RST_RENDER_WIDTH  = 15'd1920;
  localparam logic [CFG_W-1:0] RST_RENDER_HEIGHT = 15'd1080;
  localparam logic [CFG_W-1:0] RST_DISPLAY_WIDTH = 15'd1920;

  // floor(n/3) = (n * RECIP3) >> RECIP3_SHIFT for every n below 2^N_W.
  localparam logic [N_W:0] RECIP3       = 19'd349526;
  localparam int           RECIP3_SHIFT = 20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_MOD,
    ST_DIGIT,
    ST_FRAC,
    ST_UVX,
    ST_UVY
  } state_e;

  typedef enum logic [2:0] {
    OP_COUNT,
    OP_MOD,
    OP_FRAC,
    OP_UVX,
    OP_UVY
  } div_op_e;

  typedef struct packed {
    logic    div_start;
    div_op_e div_op;
    logic    ld_frame;
    logic    ld_phase;
    logic    dig_step;
    logic    ld_py;
    logic    ld_ux;
    logic    ld_out;
  } hsjg_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic n_zero;
  } hsjg_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/hsjg_div.sv =====
// ----------------------------------------------------------------------------
// hsjg_div
// Restoring divider that retires two quotient bits per cycle. It starts from
// a preset remainder and shifts in dividend bits from the top of a word.
// ----------------------------------------------------------------------------
`default_nettype none

module hsjg_div #(
  parameter int QW = 32,
  parameter int CW = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [hsjg_pkg::DIV_W-1:0]  rem_init_i,
  input  logic [hsjg_pkg::BITS_W-1:0] bits_init_i,
  input  logic [hsjg_pkg::DIV_W-1:0]  divisor_i,
  input  logic [CW-1:0]               pairs_i,
  output logic                        busy_o,
  output logic [QW-1:0]               quot_o,
  output logic [hsjg_pkg::DIV_W-1:0]  rem_o
);
  import hsjg_pkg::*;

  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [BITS_W-1:0] bits_q, bits_d;
  logic [DIV_W-1:0]  div_q, div_d;
  logic [QW-1:0]     quot_q, quot_d;

  logic [DIV_W:0]    t1, t2;
  logic [DIV_W-1:0]  r1, r2;
  logic              g1, g2;

  assign busy_o = (cnt_q != '0);
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

  // Two chained compare and subtract steps.
  always_comb begin
    t1 = {rem_q, bits_q[BITS_W-1]};
    g1 = (t1 >= {1'b0, div_q});
    r1 = g1 ? DIV_W'(t1 - {1'b0, div_q}) : t1[DIV_W-1:0];
    t2 = {r1, bits_q[BITS_W-2]};
    g2 = (t2 >= {1'b0, div_q});
    r2 = g2 ? DIV_W'(t2 - {1'b0, div_q}) : t2[DIV_W-1:0];
  end

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    bits_d = bits_q;
    div_d  = div_q;
    quot_d = quot_q;
    if (start_i) begin
      cnt_d  = pairs_i;
      rem_d  = rem_init_i;
      bits_d = bits_init_i;
      div_d  = divisor_i;
      quot_d = '0;
    end else if (busy_o) begin
      cnt_d  = cnt_q - CW'(1);
      rem_d  = r2;
      bits_d = {bits_q[BITS_W-3:0], 2'b00};
      quot_d = {quot_q[QW-3:0], g1, g2};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    bits_q <= bits_d;
    div_q  <= div_d;
    quot_q <= quot_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/hsjg_dp.sv =====
// ----------------------------------------------------------------------------
// hsjg_dp
// Datapath: configuration registers, operand selection for the shared
// divider, the base-3 digit unit, the base-2 bit reversal and the result
// registers.
// ----------------------------------------------------------------------------
`default_nettype none

module hsjg_dp #(
  parameter int FRAC_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hsjg_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [hsjg_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic [hsjg_pkg::FRAME_W-1:0] frame_index_i,
  input  hsjg_pkg::hsjg_cmd_t          cmd_i,
  output hsjg_pkg::hsjg_stat_t         stat_o,
  output logic [hsjg_pkg::JIT_W-1:0]   jitter_x_uv_o,
  output logic [hsjg_pkg::JIT_W-1:0]   jitter_y_uv_o,
  output logic [hsjg_pkg::JIT_W-1:0]   jitter_x_px_o,
  output logic [hsjg_pkg::JIT_W-1:0]   jitter_y_px_o,
  output logic [hsjg_pkg::PHASE_W-1:0] phase_o
);
  import hsjg_pkg::*;

  // Fraction bits rounded up to an even count; the extra bit is dropped later.
  localparam int FRAC_IT   = FRAC_BITS + (FRAC_BITS % 2);
  localparam int QW        = (FRAC_IT > JIT_W) ? FRAC_IT : JIT_W;
  localparam int PAIRS_MAX = (FRAC_IT / 2 > BITS_W / 2) ? FRAC_IT / 2 : BITS_W / 2;
  localparam int CW        = $clog2(PAIRS_MAX + 1);
  localparam int ALIGN_L   = (FRAC_BITS <= JIT_W) ? JIT_W - FRAC_BITS : 0;
  localparam int ALIGN_R   = (FRAC_BITS > JIT_W) ? FRAC_BITS - JIT_W : 0;
  localparam logic [JIT_W-1:0] KEEP2 =
    (FRAC_BITS >= JIT_W) ? '1 : ({JIT_W{1'b1}} << ALIGN_L);

  // Configuration.
  logic [CFG_W-1:0] rw_q, rh_q, dw_q;
  logic [CFG_W-1:0] rw_nz, rh_nz, dw_nz;

  // Working registers.
  logic [FRAME_W-1:0] frame_q;
  logic [N_W-1:0]     phase_q;
  logic [N_W-1:0]     n_q;
  logic [DIV_W-1:0]   num_q, den_q;
  logic [JIT_W-1:0]   py_q, ux_q;

  // Divider interface.
  logic [DIV_W-1:0]  rem_init, divisor;
  logic [BITS_W-1:0] bits_init;
  logic [CW-1:0]     pairs;
  logic              div_busy;
  logic [QW-1:0]     quot;
  logic [DIV_W-1:0]  rem;

  // Combinational helpers.
  logic [DIV_W-1:0]   cnt_num;
  logic [2*N_W:0]     prod;
  logic [N_W-1:0]     q3, q3x3, diff;
  logic [1:0]         digit;
  logic [N_W-1:0]     nplus;
  logic [JIT_W-1:0]   inv2, px, inv3, mag_x, mag_y;
  logic [QW-1:0]      q_frac, inv3_w;

  assign rw_nz = (rw_q == '0) ? CFG_W'(1) : rw_q;
  assign rh_nz = (rh_q == '0) ? CFG_W'(1) : rh_q;
  assign dw_nz = (dw_q == '0) ? CFG_W'(1) : dw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rw_q <= RST_RENDER_WIDTH;
      rh_q <= RST_RENDER_HEIGHT;
      dw_q <= RST_DISPLAY_WIDTH;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RENDER_WIDTH:  rw_q <= cfg_data_i;
        CFG_RENDER_HEIGHT: rh_q <= cfg_data_i;
        CFG_DISPLAY_WIDTH: dw_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Phase count numerator 8*rw + dw - 1.
  assign cnt_num = {2'b00, rw_nz, 3'b000} + {5'b00000, dw_nz} - DIV_W'(1);

  // Base-3 digit step: n / 3 by reciprocal multiply, remainder by subtract.
  always_comb begin
    prod  = (2*N_W+1)'(n_q) * (2*N_W+1)'(RECIP3);
    q3    = {1'b0, prod[2*N_W:RECIP3_SHIFT]};
    q3x3  = N_W'({q3, 1'b0} + {1'b0, q3});
    diff  = n_q - q3x3;
    digit = diff[1:0];
  end

  // Base-2 radical inverse is the bit reversal of phase+1 at the top of the word.
  always_comb begin
    nplus = phase_q + N_W'(1);
    inv2  = '0;
    for (int i = 0; i < N_W; i++) begin
      inv2[JIT_W-1-i] = nplus[i];
    end
    inv2 = inv2 & KEEP2;
    px   = {~inv2[JIT_W-1], inv2[JIT_W-2:0]};
    mag_x = px[JIT_W-1] ? (~px + JIT_W'(1)) : px;
    mag_y = py_q[JIT_W-1] ? (~py_q + JIT_W'(1)) : py_q;
  end

  // Base-3 fraction from the divider, aligned to the output scale.
  always_comb begin
    q_frac = quot >> (FRAC_IT - FRAC_BITS);
    inv3_w = (q_frac << ALIGN_L) >> ALIGN_R;
    inv3   = inv3_w[JIT_W-1:0];
  end

  // Divider operand selection.
  always_comb begin
    case (cmd_i.div_op)
      OP_COUNT: begin
        rem_init  = '0;
        bits_init = {cnt_num, {(BITS_W-DIV_W){1'b0}}};
        divisor   = DIV_W'(dw_nz);
        pairs     = CW'(DIV_W / 2);
      end
      OP_MOD: begin
        rem_init  = '0;
        bits_init = frame_q;
        divisor   = quot[DIV_W-1:0];
        pairs     = CW'(BITS_W / 2);
      end
      OP_FRAC: begin
        rem_init  = num_q;
        bits_init = '0;
        divisor   = den_q;
        pairs     = CW'(FRAC_IT / 2);
      end
      OP_UVX: begin
        rem_init  = '0;
        bits_init = mag_x;
        divisor   = DIV_W'(rw_nz);
        pairs     = CW'(BITS_W / 2);
      end
      OP_UVY: begin
        rem_init  = '0;
        bits_init = mag_y;
        divisor   = DIV_W'(rh_nz);
        pairs     = CW'(BITS_W / 2);
      end
      default: begin
        rem_init  = '0;
        bits_init = '0;
        divisor   = DIV_W'(1);
        pairs     = '0;
      end
    endcase
  end

  hsjg_div #(
    .QW (QW),
    .CW (CW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .rem_init_i  (rem_init),
    .bits_init_i (bits_init),
    .divisor_i   (divisor),
    .pairs_i     (pairs),
    .busy_o      (div_busy),
    .quot_o      (quot),
    .rem_o       (rem)
  );

  assign stat_o.div_busy = div_busy;
  assign stat_o.n_zero   = (n_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_frame) begin
      frame_q <= frame_index_i;
    end
    if (cmd_i.ld_phase) begin
      phase_q <= rem[N_W-1:0];
      n_q     <= rem[N_W-1:0] + N_W'(1);
      num_q   <= '0;
      den_q   <= DIV_W'(1);
    end else if (cmd_i.dig_step) begin
      n_q   <= q3;
      num_q <= DIV_W'({num_q, 1'b0} + {1'b0, num_q} + (DIV_W+1)'(digit));
      den_q <= DIV_W'({den_q, 1'b0} + {1'b0, den_q});
    end
    if (cmd_i.ld_py) begin
      py_q <= {~inv3[JIT_W-1], inv3[JIT_W-2:0]};
    end
    if (cmd_i.ld_ux) begin
      ux_q <= px[JIT_W-1] ? (~quot[JIT_W-1:0] + JIT_W'(1)) : quot[JIT_W-1:0];
    end
    if (cmd_i.ld_out) begin
      jitter_x_uv_o <= ux_q;
      jitter_y_uv_o <= py_q[JIT_W-1] ? (~quot[JIT_W-1:0] + JIT_W'(1)) : quot[JIT_W-1:0];
      jitter_x_px_o <= px;
      jitter_y_px_o <= py_q;
      phase_o       <= phase_q[PHASE_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hsjg_ctrl.sv =====
// ----------------------------------------------------------------------------
// hsjg_ctrl
// Controller: steps one word through phase count, phase, base-3 digits,
// fraction and texture-space divisions, and owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module hsjg_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  hsjg_pkg::hsjg_stat_t stat_i,
  output hsjg_pkg::hsjg_cmd_t  cmd_o
);
  import hsjg_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_COUNT;
      ST_COUNT: if (!stat_i.div_busy) state_d = ST_MOD;
      ST_MOD:   if (!stat_i.div_busy) state_d = ST_DIGIT;
      ST_DIGIT: if (stat_i.n_zero) state_d = ST_FRAC;
      ST_FRAC:  if (!stat_i.div_busy) state_d = ST_UVX;
      ST_UVX:   if (!stat_i.div_busy) state_d = ST_UVY;
      ST_UVY:   if (!stat_i.div_busy && out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o           = '0;
    cmd_o.div_start = (state_d != state_q) &&
                      (state_d inside {ST_COUNT, ST_MOD, ST_FRAC, ST_UVX, ST_UVY});
    case (state_d)
      ST_MOD:  cmd_o.div_op = OP_MOD;
      ST_FRAC: cmd_o.div_op = OP_FRAC;
      ST_UVX:  cmd_o.div_op = OP_UVX;
      ST_UVY:  cmd_o.div_op = OP_UVY;
      default: cmd_o.div_op = OP_COUNT;
    endcase
    cmd_o.ld_frame = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.ld_phase = (state_q == ST_MOD) && (state_d == ST_DIGIT);
    cmd_o.dig_step = (state_q == ST_DIGIT) && !stat_i.n_zero;
    cmd_o.ld_py    = (state_q == ST_FRAC) && (state_d == ST_UVX);
    cmd_o.ld_ux    = (state_q == ST_UVX) && (state_d == ST_UVY);
    cmd_o.ld_out   = (state_q == ST_UVY) && (state_d == ST_IDLE);
    in_stall_o     = (state_q != ST_IDLE);
    out_valid_o    = out_valid_q;
  end

  assign out_valid_d = cmd_o.ld_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/halton_subpixel_jitter_generator.sv =====
// ----------------------------------------------------------------------------
// halton_subpixel_jitter_generator
// Halton (2,3) sub-pixel camera jitter for temporal upscaling, one jitter
// word per frame index word.
// ----------------------------------------------------------------------------
// Usage:
//   A frame index word enters on the input channel (in_valid_i / in_stall_o)
//   and one jitter word leaves on the output channel (out_valid_o /
//   out_stall_i). A word moves at a clock edge with valid high and stall low.
//   The block works on one word at a time: in_stall_o is high from the edge
//   after acceptance until the result has been loaded into the output register.
//   Work on a word runs through the shared two-bit-per-cycle divider (phase
//   count, modulo, base-3 fraction and two texture divisions) plus a step per
//   base-3 digit of phase+1, which has 1 to 12 such digits; the fraction
//   division runs over FRAC_IT bits, FRAC_BITS rounded up to even. A new word
//   can be taken in the cycle after the previous result is loaded.
//   A finished word waits in the output register while the receiver stalls;
//   the next frame index is accepted meanwhile, and its result is held back
//   until the output register frees.
//   Reset clears the controller and the output valid flag and restores the
//   render width, render height and display width registers to 1920, 1080
//   and 1920. Configuration is written through cfg_we_i while the block idles;
//   the user must keep to this, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module halton_subpixel_jitter_generator #(
  parameter int FRAC_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [hsjg_pkg::IDX_W-1:0]          cfg_idx_i,
  input  logic [hsjg_pkg::CFG_W-1:0]          cfg_data_i,
  // Input channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [hsjg_pkg::FRAME_W-1:0]        frame_index_i,
  // Output channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [hsjg_pkg::JIT_W-1:0]   jitter_x_uv_o,
  output logic signed [hsjg_pkg::JIT_W-1:0]   jitter_y_uv_o,
  output logic signed [hsjg_pkg::JIT_W-1:0]   jitter_x_px_o,
  output logic signed [hsjg_pkg::JIT_W-1:0]   jitter_y_px_o,
  output logic [hsjg_pkg::PHASE_W-1:0]        phase_o
);
  import hsjg_pkg::*;

  // The controller sequences the work and the datapath holds every value;
  // they talk only through these two groups.
  hsjg_cmd_t  cmd;
  hsjg_stat_t stat;

  logic [JIT_W-1:0] x_uv, y_uv, x_px, y_px;

  hsjg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  hsjg_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .frame_index_i (frame_index_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .jitter_x_uv_o (x_uv),
    .jitter_y_uv_o (y_uv),
    .jitter_x_px_o (x_px),
    .jitter_y_px_o (y_px),
    .phase_o       (phase_o)
  );

  // The datapath keeps plain vectors; the ports carry them as signed values.
  assign jitter_x_uv_o = signed'(x_uv);
  assign jitter_y_uv_o = signed'(y_uv);
  assign jitter_x_px_o = signed'(x_px);
  assign jitter_y_px_o = signed'(y_px);

  // An accepted word must hold off the next one while it is worked on.
  `HSJG_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "busy not raised")
  // A result is only loaded when the output register is free.
  `HSJG_ASSERT(a_out_slot_free, cmd.ld_out |-> (!out_valid_o || !out_stall_i), "result lost")
  // The shared divider is never restarted in the middle of an operation.
  `HSJG_ASSERT(a_div_start_idle, cmd.div_start |-> !stat.div_busy, "divider restarted while busy")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Halton jitter generator testbench
// Feeds frame index words to the jitter generator under a series of raster
// settings, predicts every jitter word with an independent fixed-point model
// of the Halton (2,3) sequence and compares the results field by field.
// ----------------------------------------------------------------------------
module tb;
  import hsjg_pkg::*;

  localparam int FRAC_BITS     = 32;
  localparam int HALF_PERIOD   = 1;
  localparam int RESET_CYCLES  = 11;
  // These waits cover the time the block needs for one word, with margin.
  localparam int SETTLE_CYCLES = 120;
  localparam int END_CYCLES    = 200;
  // Longest quiet stretch of a correct run is one word's latency plus a full
  // sender gap and a full receiver stall, or one of the waits above.
  localparam int QUIET_LIMIT   = 2000;
  localparam int RAND_PHASES   = 8;
  localparam int WORDS_PER_PHASE = 48;

  // Index 3 is decoded by nobody; a write there must leave every register alone.
  localparam logic [IDX_W-1:0] CFG_SPARE = 2'd3;

  // How the registers of one random phase are chosen.
  typedef enum int {
    RASTER_ANY,    // any 15-bit value, zero included
    RASTER_LEGAL,  // inside the documented 1..16384 range
    RASTER_EDGE,   // only the extremes 0, 1, 16384 and 32767
    RASTER_TINY    // small rasters, few phases
  } raster_mix_e;

  typedef struct packed {
    logic [JIT_W-1:0]   x_uv;
    logic [JIT_W-1:0]   y_uv;
    logic [JIT_W-1:0]   x_px;
    logic [JIT_W-1:0]   y_px;
    logic [PHASE_W-1:0] phase;
  } jitter_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_W-1:0]   cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [FRAME_W-1:0] frame_index_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [JIT_W-1:0] jitter_x_uv_o;
  logic signed [JIT_W-1:0] jitter_y_uv_o;
  logic signed [JIT_W-1:0] jitter_x_px_o;
  logic signed [JIT_W-1:0] jitter_y_px_o;
  logic [PHASE_W-1:0] phase_o;

  // Frame words waiting for the driver, and jitter words the block owes us.
  logic [FRAME_W-1:0] frame_backlog[$];
  jitter_word_t       jitter_expect[$];

  // Shadow copy of the raster registers as the block should hold them.
  logic [CFG_W-1:0] raster_w;
  logic [CFG_W-1:0] raster_h;
  logic [CFG_W-1:0] display_w;

  int     words_queued = 0;  // frame words handed to the driver
  int     words_done   = 0;  // jitter words received and checked
  int     fail_count   = 0;
  int     quiet_cycles = 0;
  int     send_gap     = 0;
  int     stall_left   = 0;
  logic   frame_taken  = 1'b0;
  logic   idle_on      = 1'b1;
  longint plan_count   = 8;  // phase count of the raster now programmed

  halton_subpixel_jitter_generator #(
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .frame_index_i(frame_index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .jitter_x_uv_o(jitter_x_uv_o),
    .jitter_y_uv_o(jitter_y_uv_o),
    .jitter_x_px_o(jitter_x_px_o),
    .jitter_y_px_o(jitter_y_px_o),
    .phase_o      (phase_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Number of jitter phases: ceil(8 * render_width / display_width), with a
  // zero register read as one so the count never drops below one.
  function automatic longint phase_count(logic [CFG_W-1:0] rw, logic [CFG_W-1:0] dw);
    longint w;
    longint d;
    w = (rw == '0) ? 64'sd1 : longint'(rw);
    d = (dw == '0) ? 64'sd1 : longint'(dw);
    return (8 * w + d - 1) / d;
  endfunction

  // Digit-reversed fraction of n in the given base. The exact fraction
  // num/base^m is long-divided into FRAC_BITS bits, which truncates, and then
  // aligned to 32 fractional bits.
  function automatic logic [JIT_W-1:0] radical_inverse(longint n, longint base);
    longint num = 0;
    longint den = 1;
    longint quo = 0;
    longint rem;
    while (n > 0) begin
      num = num * base + n % base;
      den = den * base;
      n   = n / base;
    end
    rem = num;
    for (int k = 0; k < FRAC_BITS; k++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 1;
      end
    end
    if (FRAC_BITS <= 32) return JIT_W'(quo << (32 - FRAC_BITS));
    return JIT_W'(quo >> (FRAC_BITS - 32));
  endfunction

  // Jitter word for one frame index under the shadow registers. The pixel
  // offsets are the inverses minus one half; the texture offsets divide them
  // by the render size with the quotient truncated toward zero.
  function automatic jitter_word_t predict_jitter(logic [FRAME_W-1:0] frame);
    jitter_word_t w;
    longint rw;
    longint rh;
    longint ph;
    longint px;
    longint py;
    longint ux;
    longint uy;
    rw = (raster_w == '0) ? 64'sd1 : longint'(raster_w);
    rh = (raster_h == '0) ? 64'sd1 : longint'(raster_h);
    ph = {32'b0, frame};
    ph = ph % phase_count(raster_w, display_w);
    px = longint'({32'b0, radical_inverse(ph + 1, 2)}) - 64'sd2147483648;
    py = longint'({32'b0, radical_inverse(ph + 1, 3)}) - 64'sd2147483648;
    ux = px / rw;
    uy = py / rh;
    w.x_uv  = ux[JIT_W-1:0];
    w.y_uv  = uy[JIT_W-1:0];
    w.x_px  = px[JIT_W-1:0];
    w.y_px  = py[JIT_W-1:0];
    // Only the reported phase is cut to 17 bits; the sequence used it whole.
    w.phase = ph[PHASE_W-1:0];
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Register shadow and result checking
  // --------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raster_w  <= RST_RENDER_WIDTH;
      raster_h  <= RST_RENDER_HEIGHT;
      display_w <= RST_DISPLAY_WIDTH;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RENDER_WIDTH:  raster_w  <= cfg_data_i;
        CFG_RENDER_HEIGHT: raster_h  <= cfg_data_i;
        CFG_DISPLAY_WIDTH: display_w <= cfg_data_i;
        default: ;
      endcase
    end
  end

  task automatic check_field(string name, logic [JIT_W-1:0] want, logic [JIT_W-1:0] got);
    if (want !== got) begin
      $display("%0t mismatch on %s: expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // The oldest expectation is retired before a new one is queued, so a result
  // and a new frame word moving on the same edge keep their order.
  always @(posedge clk_i) begin
    jitter_word_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (jitter_expect.size() == 0) begin
          $display("%0t mismatch on jitter word: expected none, actual phase %h x_px %h",
                   $time, phase_o, jitter_x_px_o);
          fail_count++;
        end else begin
          want = jitter_expect.pop_front();
          check_field("jitter_x_uv", want.x_uv, jitter_x_uv_o);
          check_field("jitter_y_uv", want.y_uv, jitter_y_uv_o);
          check_field("jitter_x_px", want.x_px, jitter_x_px_o);
          check_field("jitter_y_px", want.y_px, jitter_y_px_o);
          check_field("phase", {15'b0, want.phase}, {15'b0, phase_o});
          words_done++;
        end
      end
      if (in_valid_i && !in_stall_o) jitter_expect.push_back(predict_jitter(frame_index_i));
      frame_taken <= in_valid_i && !in_stall_o;
    end
  end

  // --------------------------------------------------------------------------
  // Driver and receiver
  // --------------------------------------------------------------------------

  // A new frame word is offered only once the previous one has moved. Random
  // gaps are inserted between words while idling is on.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || frame_taken) begin
      if (send_gap > 0) begin
        send_gap   <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (frame_backlog.size() != 0 && idle_on && $urandom_range(0, 5) == 0) begin
        send_gap   <= $urandom_range(0, 13);
        in_valid_i <= 1'b0;
      end else if (frame_backlog.size() != 0) begin
        in_valid_i    <= 1'b1;
        frame_index_i <= frame_backlog.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // The receiver stalls in random bursts, independent of valid, so
  // stalls land on every part of the block's computation.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left  <= $urandom_range(0, 13);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // A hung block shows up as a long stretch with no word moving and no write.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
        $display("%0t watchdog: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  task automatic queue_frame(logic [FRAME_W-1:0] frame);
    frame_backlog.push_back(frame);
    words_queued++;
  endtask

  // Blocks until every queued frame word is back as a jitter word, then settles.
  task automatic settle();
    do @(negedge clk_i); while (words_done != words_queued);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
  endtask

  // Programs all three raster registers and returns on a rising edge, so the
  // frame words queued afterwards never race the driver.
  task automatic program_raster(logic [CFG_W-1:0] rw, logic [CFG_W-1:0] rh,
                                logic [CFG_W-1:0] dw);
    write_reg(CFG_RENDER_WIDTH, rw);
    write_reg(CFG_RENDER_HEIGHT, rh);
    write_reg(CFG_DISPLAY_WIDTH, dw);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    plan_count = phase_count(rw, dw);
    @(posedge clk_i);
  endtask

  function automatic logic [CFG_W-1:0] pick_reg(raster_mix_e mix);
    case (mix)
      RASTER_ANY:   return CFG_W'($urandom_range(0, 32767));
      RASTER_LEGAL: return CFG_W'($urandom_range(1, 16384));
      RASTER_EDGE: begin
        case ($urandom_range(0, 3))
          0:       return 15'd0;
          1:       return 15'd1;
          2:       return 15'd16384;
          default: return 15'd32767;
        endcase
      end
      default:      return CFG_W'($urandom_range(1, 16));
    endcase
  endfunction

  // Frame indexes: fully random, small ones that walk through the phases,
  // exact multiples of the phase count and the phase just below them, and
  // indexes near the top of the 32-bit range.
  function automatic logic [FRAME_W-1:0] pick_frame(longint count);
    longint f;
    case ($urandom_range(0, 3))
      0:       f = longint'($urandom);
      1:       f = longint'($urandom_range(0, 32'(3 * count)));
      2:       f = count * $urandom_range(0, 16383) + (($urandom_range(0, 1) == 1) ? count - 1 : 0);
      default: f = longint'($urandom | 32'hF000_0000);
    endcase
    return f[FRAME_W-1:0];
  endfunction

  initial begin
    raster_mix_e mix;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset raster: eight phases. Walk all of them, through the wrap, and
    // the extremes of the frame index.
    for (int f = 0; f <= 8; f++) queue_frame(f);
    queue_frame(32'hFFFF_FFFF);
    queue_frame(32'h8000_0000);
    queue_frame(32'h7FFF_FFFF);
    settle();

    // Zero registers read as one. The spare index must change nothing.
    write_reg(CFG_SPARE, 15'h7FFF);
    program_raster(15'd0, 15'd0, 15'd0);
    queue_frame(32'd0);
    queue_frame(32'd7);
    queue_frame(32'hFFFF_FFFF);
    settle();

    // Widest phase count: 262136 phases, so the reported phase wraps at 2^17
    // and phase+1 reaches twelve base-3 digits.
    program_raster(15'd32767, 15'd32767, 15'd1);
    queue_frame(32'd262135);
    queue_frame(32'd131072);
    queue_frame(32'd177146);
    queue_frame(32'd262136);
    queue_frame(32'hFFFF_FFFF);
    settle();

    // Single phase: the jitter never moves.
    program_raster(15'd1, 15'd16384, 15'd32767);
    queue_frame(32'd0);
    queue_frame(32'hFFFF_FFFF);
    settle();

    // Random rasters. The last phase runs without any idling on either side.
    for (int p = 0; p < RAND_PHASES; p++) begin
      mix = (p == RAND_PHASES - 1) ? RASTER_LEGAL : raster_mix_e'($urandom_range(0, 3));
      program_raster(pick_reg(mix), pick_reg(mix), pick_reg(mix));
      idle_on <= (p == RAND_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        // Once, hold the sender back halfway until the block has drained.
        if (p == 3 && i == WORDS_PER_PHASE / 2) begin
          do @(negedge clk_i); while (words_done != words_queued);
          @(posedge clk_i);
        end
        queue_frame(pick_frame(plan_count));
      end
      settle();
    end

    repeat (END_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && jitter_expect.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
